// ----- sv/kdee_pkg.sv -----
// ----------------------------------------------------------------------------
// kdee_pkg
// Shared types and constants for the keypad debounce and event engine.
// ----------------------------------------------------------------------------
package kdee_pkg;

    localparam int unsigned NUM_KEYS = 16;
    localparam int unsigned KEY_W    = 4;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_ACK   = 2'd1,
        OP_FORCE = 2'd2,
        OP_FLUSH = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        CFG_MODE   = 3'd0,
        CFG_GROUP  = 3'd1,
        CFG_LEVEL  = 3'd2,
        CFG_DEB    = 3'd3,
        CFG_BREAK  = 3'd4,
        CFG_PERIOD = 3'd5,
        CFG_LONG   = 3'd6,
        CFG_LONG2  = 3'd7
    } t_cfg_idx;

    localparam logic [1:0] DB_IDLE = 2'd0;
    localparam logic [1:0] DB_VPRS = 2'd1;
    localparam logic [1:0] DB_HELD = 2'd2;
    localparam logic [1:0] DB_VREL = 2'd3;

    localparam logic [3:0] ST_START    = 4'd0;
    localparam logic [3:0] ST_REL      = 4'd1;
    localparam logic [3:0] ST_REL2     = 4'd2;
    localparam logic [3:0] ST_WAITREAD = 4'd3;
    localparam logic [3:0] ST_LONG     = 4'd4;
    localparam logic [3:0] ST_LONG2    = 4'd5;
    localparam logic [3:0] ST_ONREL    = 4'd6;
    localparam logic [3:0] ST_WHILE    = 4'd7;
    localparam logic [3:0] ST_REP      = 4'd8;
    localparam logic [3:0] ST_REP1     = 4'd9;
    localparam logic [3:0] ST_REP2     = 4'd10;
    localparam logic [3:0] ST_END      = 4'd11;

    localparam logic [2:0] MODE_PRESS   = 3'd1;
    localparam logic [2:0] MODE_RELEASE = 3'd2;
    localparam logic [2:0] MODE_WHILE   = 3'd3;
    localparam logic [2:0] MODE_LONG    = 3'd4;
    localparam logic [2:0] MODE_LONG2   = 3'd5;

    typedef struct packed {
        logic             start;   // load a beat
        logic             step;    // process key at r_key
        logic             clear;   // return the op to acknowledge
        logic [KEY_W-1:0] key;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic last_key;
    } t_status;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

// ----- sv/kdee_ctrl.sv -----
// ----------------------------------------------------------------------------
// kdee_ctrl
// Sequencer: accepts a beat, walks the keys on a tick, presents the result.
// ----------------------------------------------------------------------------
module kdee_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    input  kdee_pkg::t_status  i_status,
    output kdee_pkg::t_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_DONE = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                       r_state, n_state;
    logic [kdee_pkg::KEY_W-1:0]   r_key, n_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_key   <= '0;
        end else begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        o_cmd.start = 1'b0;
        o_cmd.step  = 1'b0;
        o_cmd.clear = 1'b0;
        o_cmd.key   = r_key;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_key       = '0;
                    n_state     = S_WALK;
                end
            end
            S_WALK: begin
                if (!i_status.is_tick) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_key      = r_key + 1'b1;
                    if (i_status.last_key) n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.clear = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

endmodule

// ----- sv/kdee_dp.sv -----
// ----------------------------------------------------------------------------
// kdee_dp
// Per-key state, configuration and the shared debounce/event step unit.
// ----------------------------------------------------------------------------
module kdee_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    input  logic [1:0]         i_opcode,
    input  logic [15:0]        i_pin_levels,
    input  logic [3:0]         i_key_index,
    input  kdee_pkg::t_cmd     i_cmd,
    output kdee_pkg::t_status  o_status,
    output logic [15:0]        o_ready_mask,
    output logic [15:0]        o_after_threshold_mask,
    output logic [15:0]        o_pressed_mask,
    output logic [15:0]        o_busy_mask,
    output logic               o_all_released,
    output logic               o_all_finished
);

    localparam int unsigned NK = kdee_pkg::NUM_KEYS;

    logic [63:0] r_mode_map, r_group_map;
    logic        r_level;
    logic [7:0]  r_deb;
    logic [15:0] r_brk, r_per, r_lp, r_lp2;

    logic [1:0]  r_phase [NK];
    logic [7:0]  r_dcnt  [NK];
    logic [3:0]  r_stage [NK];
    logic [15:0] r_timer [NK];
    logic [NK-1:0] r_prs, r_rdy, r_aft, r_own, r_bsy;
    logic [15:0] r_lock;
    logic [1:0]  r_op;
    logic [15:0] r_pins;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_map  <= 64'h1111_1111_1111_1111;
            r_group_map <= '0;
            r_level     <= 1'b0;
            r_deb       <= 8'd20;
            r_brk       <= 16'd100;
            r_per       <= 16'd20;
            r_lp        <= 16'd200;
            r_lp2       <= 16'd600;
        end else if (i_cfg_we) begin
            unique case (kdee_pkg::t_cfg_idx'(i_cfg_idx))
                kdee_pkg::CFG_MODE:   r_mode_map  <= i_cfg_data;
                kdee_pkg::CFG_GROUP:  r_group_map <= i_cfg_data;
                kdee_pkg::CFG_LEVEL:  r_level     <= i_cfg_data[0];
                kdee_pkg::CFG_DEB:    r_deb       <= i_cfg_data[7:0];
                kdee_pkg::CFG_BREAK:  r_brk       <= i_cfg_data[15:0];
                kdee_pkg::CFG_PERIOD: r_per       <= i_cfg_data[15:0];
                kdee_pkg::CFG_LONG:   r_lp        <= i_cfg_data[15:0];
                kdee_pkg::CFG_LONG2:  r_lp2       <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // step unit: one key per cycle
    logic [3:0]  k;
    logic [2:0]  mode;
    logic        rep;
    logic [3:0]  grp;
    logic [1:0]  ph, n_ph;
    logic [7:0]  dc, n_dc;
    logic        at_press, prs;
    logic [3:0]  st;
    logic [15:0] t;
    logic        rdy, aft, own, bsy, n_lock_set, n_lock_clr;

    always_comb begin
        k        = i_cmd.key;
        mode     = r_mode_map[4*k +: 3];
        rep      = r_mode_map[4*k + 3];
        grp      = r_group_map[4*k +: 4];
        at_press = (r_pins[k] == r_level);
        ph       = r_phase[k];
        dc       = r_dcnt[k];
        prs      = r_prs[k];
        n_ph     = ph;
        n_dc     = dc;
        if (ph == kdee_pkg::DB_IDLE) begin
            if (at_press) n_ph = kdee_pkg::DB_VPRS;
        end else if (ph == kdee_pkg::DB_HELD) begin
            if (!at_press) n_ph = kdee_pkg::DB_VREL;
        end else begin
            n_dc = dc + 8'd1;
            if (n_dc == r_deb) begin
                n_dc = '0;
                if (ph == kdee_pkg::DB_VPRS) begin
                    if (at_press) begin
                        prs = 1'b1;
                        n_ph = kdee_pkg::DB_HELD;
                    end else n_ph = kdee_pkg::DB_IDLE;
                end else begin
                    if (!at_press) begin
                        prs = 1'b0;
                        n_ph = kdee_pkg::DB_IDLE;
                    end else n_ph = kdee_pkg::DB_HELD;
                end
            end
        end

        st  = r_stage[k];
        t   = r_timer[k];
        rdy = r_rdy[k];
        aft = r_aft[k];
        own = r_own[k];
        bsy = r_bsy[k];
        n_lock_set = 1'b0;
        n_lock_clr = 1'b0;

        if (st == kdee_pkg::ST_START) begin
            if (!(grp != 4'd0 && r_lock[grp] && !own) && prs
                && mode >= kdee_pkg::MODE_PRESS && mode <= kdee_pkg::MODE_LONG2) begin
                priority case (mode)
                    kdee_pkg::MODE_PRESS: begin
                        rdy = 1'b1;
                        st  = rep ? kdee_pkg::ST_REP : kdee_pkg::ST_REL;
                    end
                    kdee_pkg::MODE_RELEASE: st = kdee_pkg::ST_ONREL;
                    kdee_pkg::MODE_WHILE:   st = kdee_pkg::ST_WHILE;
                    kdee_pkg::MODE_LONG:    st = kdee_pkg::ST_LONG;
                    default:                st = kdee_pkg::ST_LONG2;
                endcase
                bsy = 1'b1;
                if (grp != 4'd0) begin
                    n_lock_set = 1'b1;
                    own = 1'b1;
                end
            end
        end
        if (st >= kdee_pkg::ST_REP && st <= kdee_pkg::ST_REP2 && !prs) begin
            t  = '0;
            st = kdee_pkg::ST_WAITREAD;
        end
        if (st == kdee_pkg::ST_REP) begin
            t = kdee_pkg::sat_inc(t);
            if (t >= r_brk) begin
                t  = '0;
                st = kdee_pkg::ST_REP1;
            end
        end
        if (st == kdee_pkg::ST_REP1 && !rdy) begin
            rdy = 1'b1;
            st  = kdee_pkg::ST_REP2;
        end
        if (st == kdee_pkg::ST_REP2) begin
            t = kdee_pkg::sat_inc(t);
            if (t >= r_per) begin
                t  = '0;
                st = kdee_pkg::ST_REP1;
            end
        end
        if (st == kdee_pkg::ST_ONREL && !prs) begin
            rdy = 1'b1;
            st  = kdee_pkg::ST_WAITREAD;
        end
        if (st == kdee_pkg::ST_WHILE) begin
            rdy = 1'b1;
            st  = kdee_pkg::ST_REL2;
        end
        if (st == kdee_pkg::ST_LONG || st == kdee_pkg::ST_LONG2) begin
            t = kdee_pkg::sat_inc(t);
            if (!prs && t <= r_lp) begin
                t   = '0;
                rdy = 1'b1;
                aft = 1'b0;
                st  = kdee_pkg::ST_WAITREAD;
            end
            if (st == kdee_pkg::ST_LONG && t > r_lp) begin
                t   = '0;
                rdy = 1'b1;
                aft = 1'b1;
                st  = rep ? kdee_pkg::ST_REP2 : kdee_pkg::ST_REL;
            end
            if (st == kdee_pkg::ST_LONG2 && t >= r_lp2) begin
                t   = '0;
                rdy = 1'b1;
                aft = 1'b1;
                st  = kdee_pkg::ST_REL2;
            end
        end
        if (st == kdee_pkg::ST_REL && !prs) st = kdee_pkg::ST_WAITREAD;
        if (st == kdee_pkg::ST_REL2 && !prs) begin
            rdy = 1'b0;
            st  = kdee_pkg::ST_END;
        end
        if (st == kdee_pkg::ST_WAITREAD && !rdy) st = kdee_pkg::ST_END;
        if (st == kdee_pkg::ST_END) begin
            if (grp != 4'd0) begin
                n_lock_clr = 1'b1;
                own = 1'b0;
            end
            st  = kdee_pkg::ST_START;
            bsy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prs  <= '0;
            r_rdy  <= '0;
            r_aft  <= '0;
            r_own  <= '0;
            r_bsy  <= '0;
            r_lock <= '0;
            for (int i = 0; i < NK; i++) begin
                r_phase[i] <= kdee_pkg::DB_IDLE;
                r_dcnt[i]  <= '0;
                r_stage[i] <= kdee_pkg::ST_START;
                r_timer[i] <= '0;
            end
        end else if (i_cmd.start) begin
            r_op   <= i_opcode;
            r_pins <= i_pin_levels;
            unique case (kdee_pkg::t_opcode'(i_opcode))
                kdee_pkg::OP_ACK:   r_rdy[i_key_index] <= 1'b0;
                kdee_pkg::OP_FORCE: r_rdy[i_key_index] <= 1'b1;
                kdee_pkg::OP_FLUSH: r_rdy <= '0;
                default: ;
            endcase
        end else if (i_cmd.step) begin
            r_phase[k] <= n_ph;
            r_dcnt[k]  <= n_dc;
            r_stage[k] <= st;
            r_timer[k] <= t;
            r_prs[k]   <= prs;
            r_rdy[k]   <= rdy;
            r_aft[k]   <= aft;
            r_own[k]   <= own;
            r_bsy[k]   <= bsy;
            // unlock wins when a key both takes and frees its group
            if (n_lock_set || n_lock_clr) r_lock[grp] <= !n_lock_clr;
        end else if (i_cmd.clear) begin
            r_op <= kdee_pkg::OP_ACK;
        end
    end

    assign o_status.is_tick  = (r_op == kdee_pkg::OP_TICK);
    assign o_status.last_key = (k == 4'(NK - 1));

    assign o_ready_mask           = r_rdy;
    assign o_after_threshold_mask = r_aft;
    assign o_pressed_mask         = r_prs;
    assign o_busy_mask            = r_bsy;
    assign o_all_released         = (r_prs == '0);
    assign o_all_finished         = (r_bsy == '0);

endmodule

// ----- sv/keypad_debounce_event_engine.sv -----
// ----------------------------------------------------------------------------
// keypad_debounce_event_engine
// Debounces up to 16 keys and runs per-key press/release/long-press events.
// ----------------------------------------------------------------------------
// channel | valid   | stall   | payload
// in      | i_valid | o_stall | i_opcode, i_pin_levels, i_key_index
// out     | o_valid | i_stall | o_ready_mask .. o_all_finished
//
// A scan tick steps the keys one per cycle through one shared debounce/event
// unit, in index order for group priority. Acknowledge, force and flush skip
// the key walk. One beat is in flight at a time; the result register holds
// while the output is stalled. Reset is synchronous and restores all registers
// but the latched opcode and pin levels to their reset values.
// ----------------------------------------------------------------------------
module keypad_debounce_event_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_pin_levels,
    input  logic [3:0]  i_key_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_ready_mask,
    output logic [15:0] o_after_threshold_mask,
    output logic [15:0] o_pressed_mask,
    output logic [15:0] o_busy_mask,
    output logic        o_all_released,
    output logic        o_all_finished
);

    kdee_pkg::t_cmd    cmd;
    kdee_pkg::t_status status;

    kdee_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    kdee_dp u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_idx              (i_cfg_idx),
        .i_cfg_data             (i_cfg_data),
        .i_opcode               (i_opcode),
        .i_pin_levels           (i_pin_levels),
        .i_key_index            (i_key_index),
        .i_cmd                  (cmd),
        .o_status               (status),
        .o_ready_mask           (o_ready_mask),
        .o_after_threshold_mask (o_after_threshold_mask),
        .o_pressed_mask         (o_pressed_mask),
        .o_busy_mask            (o_busy_mask),
        .o_all_released         (o_all_released),
        .o_all_finished         (o_all_finished)
    );

endmodule

// ----- sv/kdee_checker.sv -----
// ----------------------------------------------------------------------------
// kdee_checker
// Port-level checks for the keypad debounce and event engine.
// ----------------------------------------------------------------------------
module kdee_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_pressed_mask,
    input logic [15:0] o_busy_mask,
    input logic        o_all_released,
    input logic        o_all_finished
);

    a_summary_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_all_released == (o_pressed_mask == 16'd0))
        else $error("all_released disagrees with pressed mask");

    a_summary_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_all_finished == (o_busy_mask == 16'd0))
        else $error("all_finished disagrees with busy mask");

    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result pending");

    // hold off the next beat once one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second beat taken while one is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_busy_mask))
        else $error("stalled result changed");

endmodule

bind keypad_debounce_event_engine kdee_checker u_kdee_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_pressed_mask (o_pressed_mask),
    .o_busy_mask    (o_busy_mask),
    .o_all_released (o_all_released),
    .o_all_finished (o_all_finished)
);
